### hw/rtl/utf8_encoder_six_byte_top_assert.svh
// Assertion helpers for the UTF-8 encoder.
// Each check is clocked on a rising edge and is held off while reset is high.
`ifndef UTF8_ENCODER_SIX_BYTE_TOP_ASSERT_SVH
`define UTF8_ENCODER_SIX_BYTE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define UTF8E_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("utf8e assertion failed");

`define UTF8E_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("utf8e forbidden condition seen");

`else

`define UTF8E_ASSERT(label, clk, rst, prop)

`define UTF8E_NEVER(label, clk, rst, expr)

`endif

`endif

### hw/rtl/utf8e_pkg.sv
package utf8e_pkg;

   // Default depth of the queue between the classifier and the byte serializer
   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] CRLF_RESET = 32'hffff_ffff;

   // Entry kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_CRLF = 1'b1;

   localparam logic [7:0] BYTE_CR = 8'h0d;
   localparam logic [7:0] BYTE_LF = 8'h0a;

   // Lead byte prefixes for two to six byte sequences, continuation prefix
   localparam logic [7:0] LEAD_2 = 8'hc0;
   localparam logic [7:0] LEAD_3 = 8'he0;
   localparam logic [7:0] LEAD_4 = 8'hf0;
   localparam logic [7:0] LEAD_5 = 8'hf8;
   localparam logic [7:0] LEAD_6 = 8'hfc;
   localparam logic [7:0] CONT   = 8'h80;

   // First code of each sequence length
   localparam logic [30:0] MIN_2 = 31'h0000_0080;
   localparam logic [30:0] MIN_3 = 31'h0000_0800;
   localparam logic [30:0] MIN_4 = 31'h0001_0000;
   localparam logic [30:0] MIN_5 = 31'h0020_0000;
   localparam logic [30:0] MIN_6 = 31'h0400_0000;

   typedef struct packed {
      logic        kind;
      logic [2:0]  len;    // bytes in the sequence, 1 to 6
      logic [30:0] code;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

endpackage

### hw/rtl/utf8_encoder_six_byte_top.sv
// UTF-8 encoder, original six-byte scheme covering 31-bit codes. Each item on
// the req_ channel is one code point; the rsp_ channel returns its encoded
// bytes one per item, lead byte first, with rsp_last_byte high on the final
// byte. A code equal to the csr_ register (reset value 0xffffffff) encodes as
// CR then LF, and this check wins over everything else; any other code above
// 0x7fffffff produces no output at all. Throughput is one output byte per
// clock while rsp_stall is low: a code point gives 1 to 6 bytes (2 for the
// newline code), sent by the byte serializer at the back. A code that gives
// no output never enters the queue. The front classifier takes a new item
// every clock while the queue between the two halves has room, so short
// bursts of input are absorbed while long sequences drain. An accepted code
// point goes into the queue, and its first byte then into the output register.
// The csr_ port is always ready; write it only while no items are in flight.
module utf8_encoder_six_byte_top #(
   parameter int QueueDepth = utf8e_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel: one code point per item
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_code_point,
   // response channel: one encoded byte per item
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte,
   // newline code register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   utf8e_pkg::slot_type push;
   utf8e_pkg::slot_type head;
   logic                q_full;
   logic                pop;

   // Front: hold the newline code, classify each code point, drop those
   // that encode to nothing
   utf8e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .q_full         (q_full),
      .push           (push)
   );

   // Queue: decouple classification from byte output
   utf8e_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   // Back: walk the head entry byte by byte into the output register,
   // advance to the next entry on its last byte
   utf8e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

### hw/rtl/utf8e_front.sv
module utf8e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_code_point,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_data,
   input  logic                q_full,
   output utf8e_pkg::slot_type push
);

   logic [31:0] crlf_ff;
   logic [31:0] crlf_in;
   logic        match;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign crlf_in   = (csr_valid && csr_ready) ? csr_data : crlf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crlf_ff <= utf8e_pkg::CRLF_RESET;
      end else begin
         crlf_ff <= crlf_in;
      end
   end

   assign match = (req_code_point == crlf_ff);

   // Classify: newline code first, then sequence length; drop codes above 31 bits
   always_comb begin
      push.entry.code = req_code_point[30:0];
      push.entry.kind = utf8e_pkg::KIND_CHAR;
      if (match) begin
         push.entry.kind = utf8e_pkg::KIND_CRLF;
         push.entry.len  = 3'd2;
      end else if (req_code_point[30:0] >= utf8e_pkg::MIN_6) begin
         push.entry.len = 3'd6;
      end else if (req_code_point[30:0] >= utf8e_pkg::MIN_5) begin
         push.entry.len = 3'd5;
      end else if (req_code_point[30:0] >= utf8e_pkg::MIN_4) begin
         push.entry.len = 3'd4;
      end else if (req_code_point[30:0] >= utf8e_pkg::MIN_3) begin
         push.entry.len = 3'd3;
      end else if (req_code_point[30:0] >= utf8e_pkg::MIN_2) begin
         push.entry.len = 3'd2;
      end else begin
         push.entry.len = 3'd1;
      end
      push.valid = req_valid && !req_stall && (match || !req_code_point[31]);
   end

endmodule

### hw/rtl/utf8e_queue.sv
`include "utf8_encoder_six_byte_top_assert.svh"

module utf8e_queue #(
   parameter int Depth = utf8e_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  utf8e_pkg::slot_type push,
   output logic                full,
   output utf8e_pkg::slot_type head,
   input  logic                pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   utf8e_pkg::entry_type slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntW'(Depth));
   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

   `UTF8E_NEVER(a_no_push_when_full, clock, reset, full && push.valid)
   `UTF8E_NEVER(a_no_pop_when_empty, clock, reset, pop && !head.valid)
   `UTF8E_ASSERT(a_count_bounded, clock, reset, count_ff <= CntW'(Depth))

endmodule

### hw/rtl/utf8e_back.sv
`include "utf8_encoder_six_byte_top_assert.svh"

module utf8e_back (
   input  logic                clock,
   input  logic                reset,
   input  utf8e_pkg::slot_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_byte
);

   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_out_byte_ff;
   logic        rsp_last_byte_ff;
   logic [7:0]  byte_val;
   logic        last;
   logic        load;
   logic [2:0]  rem;
   logic [30:0] c;

   assign c    = head.entry.code;
   assign last = (idx_ff == head.entry.len - 3'd1);
   assign rem  = head.entry.len - 3'd1 - idx_ff;
   assign load = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && last;

   // Byte at position idx_ff of the head entry
   always_comb begin
      byte_val = '0;
      if (head.entry.kind == utf8e_pkg::KIND_CRLF) begin
         byte_val = (idx_ff == 3'd0) ? utf8e_pkg::BYTE_CR : utf8e_pkg::BYTE_LF;
      end else if (head.entry.len == 3'd1) begin
         byte_val = {1'b0, c[6:0]};
      end else if (idx_ff == 3'd0) begin
         unique case (head.entry.len)
            3'd2:    byte_val = utf8e_pkg::LEAD_2 | {3'b0, c[10:6]};
            3'd3:    byte_val = utf8e_pkg::LEAD_3 | {4'b0, c[15:12]};
            3'd4:    byte_val = utf8e_pkg::LEAD_4 | {5'b0, c[20:18]};
            3'd5:    byte_val = utf8e_pkg::LEAD_5 | {6'b0, c[25:24]};
            3'd6:    byte_val = utf8e_pkg::LEAD_6 | {7'b0, c[30]};
            default: byte_val = '0;
         endcase
      end else begin
         unique case (rem)
            3'd0:    byte_val = utf8e_pkg::CONT | {2'b0, c[5:0]};
            3'd1:    byte_val = utf8e_pkg::CONT | {2'b0, c[11:6]};
            3'd2:    byte_val = utf8e_pkg::CONT | {2'b0, c[17:12]};
            3'd3:    byte_val = utf8e_pkg::CONT | {2'b0, c[23:18]};
            3'd4:    byte_val = utf8e_pkg::CONT | {2'b0, c[29:24]};
            default: byte_val = '0;
         endcase
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = head.valid;
      end
      if (load) begin
         idx_in = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_out_byte_ff  <= byte_val;
         rsp_last_byte_ff <= last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

   `UTF8E_ASSERT(a_idx_in_range, clock, reset, !head.valid || (idx_ff < head.entry.len))
   `UTF8E_ASSERT(a_mid_seq_holds_head, clock, reset, (idx_ff == 3'd0) || head.valid)
   `UTF8E_ASSERT(a_pop_marks_last, clock, reset, pop |=> (rsp_valid_ff && rsp_last_byte_ff))

endmodule

### sim/utf8_encoder_six_byte_top_tb.sv
module utf8_encoder_six_byte_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_ITEMS = 48;

   // One code point to send, with its byte sequence when it is typed in by hand.
   // Bytes are left-justified: the lead byte sits in seq[47:40].
   typedef struct packed {
      logic [31:0] code;
      logic        fixed;
      logic [2:0]  count;
      logic [47:0] seq;
   } code_plan_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } utf8_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_code_point = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   code_plan_type directed_rows[$];
   code_plan_type plans[$];       // sent code points not yet accepted, oldest first
   utf8_byte_type bytes_due[$];   // encoded bytes still to come out, oldest first

   logic [31:0] crlf_shadow = utf8e_pkg::CRLF_RESET;
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          no_gaps = 1'b0;

   // Long receiver hold-off, requested by the stimulus and timed in its own process
   int          hold_asked = 0;
   int          hold_served = 0;
   logic        hold_active = 1'b0;

   // Receiver stall pattern
   int          stall_mode = 0;
   int          mode_left = 0;
   int          mode_tick = 0;
   logic        stall_now;

   utf8_encoder_six_byte_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Encode one code point the way the block should: the newline code wins over
   // everything, codes with bit 31 set give nothing, the rest take 1 to 6 bytes.
   function automatic logic [2:0] encode_utf8(input logic [31:0] cp, input logic [31:0] nl,
                                              output logic [47:0] seq);
      logic [2:0] n;
      logic [7:0] prefix;
      logic [7:0] mask;
      int         k;
      seq = '0;
      if (cp == nl) begin
         seq[47:40] = utf8e_pkg::BYTE_CR;
         seq[39:32] = utf8e_pkg::BYTE_LF;
         return 3'd2;
      end
      if (cp[31])
         return 3'd0;
      if (cp[30:0] >= utf8e_pkg::MIN_6) begin
         n = 3'd6;
         prefix = utf8e_pkg::LEAD_6;
      end else if (cp[30:0] >= utf8e_pkg::MIN_5) begin
         n = 3'd5;
         prefix = utf8e_pkg::LEAD_5;
      end else if (cp[30:0] >= utf8e_pkg::MIN_4) begin
         n = 3'd4;
         prefix = utf8e_pkg::LEAD_4;
      end else if (cp[30:0] >= utf8e_pkg::MIN_3) begin
         n = 3'd3;
         prefix = utf8e_pkg::LEAD_3;
      end else if (cp[30:0] >= utf8e_pkg::MIN_2) begin
         n = 3'd2;
         prefix = utf8e_pkg::LEAD_2;
      end else begin
         seq[47:40] = {1'b0, cp[6:0]};
         return 3'd1;
      end
      // The lead byte keeps 7 - n payload bits below its prefix.
      mask = 8'hff >> (n + 1);
      seq[47:40] = prefix | (8'(cp >> (6 * (n - 1))) & mask);
      for (k = 1; k < n; k++)
         seq[47 - 8 * k -: 8] = utf8e_pkg::CONT | {2'b00, 6'(cp >> (6 * (n - 1 - k)))};
      return n;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH @%0d: %s", cycle_count, what);
   endtask

   // Track the register, expand each accepted code point into its bytes and
   // check every accepted byte against the oldest one due.
   always @(posedge clock) begin : scoreboard
      code_plan_type plan;
      utf8_byte_type got;
      utf8_byte_type want;
      int            k;
      if (!reset) begin
         if (csr_valid && csr_ready)
            crlf_shadow = csr_data;
         if (req_valid && !req_stall) begin
            if (plans.size() == 0) begin
               report_mismatch($sformatf("code point %h accepted but never sent",
                                         req_code_point));
            end else begin
               plan = plans.pop_front();
               // Typed-in rows keep their bytes; all others go through the encoder.
               if (!plan.fixed)
                  plan.count = encode_utf8(req_code_point, crlf_shadow, plan.seq);
               for (k = 0; k < plan.count; k++)
                  bytes_due.push_back({plan.seq[47 - 8 * k -: 8], 1'(k == plan.count - 1)});
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_byte, rsp_last_byte};
            if (bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h last %b",
                                         rsp_out_byte, rsp_last_byte));
            end else begin
               want = bytes_due.pop_front();
               if (got.value !== want.value)
                  report_mismatch($sformatf("out_byte %h, want %h", got.value, want.value));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last_byte %b, want %b on byte %h",
                                            got.last, want.last, want.value));
            end
         end
      end
   end

   // Hold the receiver off for a long stretch whenever the stimulus asks.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served++;
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
         end
      end
   end

   // Receiver stall pattern: switch between free flow, light and heavy random
   // stalls and a fixed duty cycle.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(64, 256);
      end else begin
         mode_left--;
      end
      mode_tick++;
      case (stall_mode)
         0: stall_now = 1'b0;
         1: stall_now = ($urandom_range(0, 3) == 0);
         2: stall_now = ($urandom_range(0, 9) < 7);
         default: stall_now = ((mode_tick % 7) < 3);
      endcase
      rsp_stall <= hold_active || stall_now;
   end

   task automatic add_row(input logic [31:0] code, input logic fixed, input logic [2:0] count,
                          input logic [47:0] seq);
      directed_rows.push_back({code, fixed, count, seq});
   endtask

   // Offer one code point and hold it until the block takes it.
   task automatic send_plan(input code_plan_type plan);
      plans.push_back(plan);
      req_valid <= 1'b1;
      req_code_point <= plan.code;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_input(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Bursts of random length, random gaps between them.
   task automatic pace_input();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = 0;
         if (!no_gaps && $urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 10);
         if (gap > 0)
            idle_input(gap);
      end
      burst_left--;
   endtask

   // Drain everything in flight, then write.
   task automatic write_crlf(input logic [31:0] value);
      req_valid <= 1'b0;
      while (plans.size() != 0 || bytes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Random code point: mostly well-formed codes spread over every length, with
   // the newline code, boundaries, codes above 0x7fffffff and raw words mixed in.
   function automatic logic [31:0] pick_code();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10)
         return crlf_shadow;
      if (sel < 17)
         return {1'b1, 31'($urandom())};
      if (sel < 22)
         return $urandom();
      if (sel < 32) begin
         case ($urandom_range(0, 13))
            0: return 32'h0000_0000;
            1: return 32'h0000_007f;
            2: return 32'h0000_0080;
            3: return 32'h0000_07ff;
            4: return 32'h0000_0800;
            5: return 32'h0000_ffff;
            6: return 32'h0001_0000;
            7: return 32'h001f_ffff;
            8: return 32'h0020_0000;
            9: return 32'h03ff_ffff;
            10: return 32'h0400_0000;
            11: return 32'h7fff_ffff;
            12: return 32'h8000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      if (sel < 44)
         return $urandom_range(32'h7f, 0);
      case ($urandom_range(2, 6))
         2: return $urandom_range(32'h0000_07ff, 32'h0000_0080);
         3: return $urandom_range(32'h0000_ffff, 32'h0000_0800);
         4: return $urandom_range(32'h001f_ffff, 32'h0001_0000);
         5: return $urandom_range(32'h03ff_ffff, 32'h0020_0000);
         default: return $urandom_range(32'h7fff_ffff, 32'h0400_0000);
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0] settings[6];
      int          p;
      int          i;

      // Walk the newline register through its extremes and a few points between.
      settings[0] = 32'h0000_0000;
      settings[1] = 32'h7fff_ffff;
      settings[2] = 32'h8000_0000;
      settings[3] = $urandom();
      settings[4] = 32'h0000_0800;
      settings[5] = 32'hffff_ffff;

      // Directed rows, all under the reset value of the newline register. The
      // first one is the reset value itself, which must come out as CR LF.
      add_row(32'hffff_ffff, 1'b1, 3'd2, 48'h0d0a_0000_0000);
      add_row(32'h0000_0000, 1'b1, 3'd1, 48'h0000_0000_0000);
      add_row(32'h0000_007f, 1'b1, 3'd1, 48'h7f00_0000_0000);
      add_row(32'h0000_0080, 1'b1, 3'd2, 48'hc280_0000_0000);
      add_row(32'h0000_07ff, 1'b1, 3'd2, 48'hdfbf_0000_0000);
      add_row(32'h0000_0800, 1'b1, 3'd3, 48'he0a0_8000_0000);
      add_row(32'h0000_ffff, 1'b1, 3'd3, 48'hefbf_bf00_0000);
      add_row(32'h0001_0000, 1'b1, 3'd4, 48'hf090_8080_0000);
      add_row(32'h001f_ffff, 1'b1, 3'd4, 48'hf7bf_bfbf_0000);
      add_row(32'h0020_0000, 1'b1, 3'd5, 48'hf888_8080_8000);
      add_row(32'h03ff_ffff, 1'b1, 3'd5, 48'hfbbf_bfbf_bf00);
      add_row(32'h0400_0000, 1'b1, 3'd6, 48'hfc84_8080_8080);
      add_row(32'h7fff_ffff, 1'b1, 3'd6, 48'hfdbf_bfbf_bfbf);
      // Above 0x7fffffff and not the newline code: nothing comes out.
      add_row(32'h8000_0000, 1'b1, 3'd0, 48'h0);
      add_row(32'hffff_fffe, 1'b1, 3'd0, 48'h0);
      add_row(32'h0000_0041, 1'b0, 3'd0, 48'h0);
      add_row(32'h0000_03b1, 1'b0, 3'd0, 48'h0);
      add_row(32'h0000_20ac, 1'b0, 3'd0, 48'h0);
      add_row(32'h0001_f600, 1'b0, 3'd0, 48'h0);
      add_row(32'h1234_5678, 1'b0, 3'd0, 48'h0);
      add_row(32'h5555_5555, 1'b0, 3'd0, 48'h0);
      add_row(32'h2aaa_aaaa, 1'b0, 3'd0, 48'h0);
      add_row(32'haaaa_aaaa, 1'b0, 3'd0, 48'h0);
      add_row(32'h7fff_fffe, 1'b0, 3'd0, 48'h0);

      // Hold reset at the start, then release it.
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         send_plan(directed_rows[r]);
         pace_input();
      end

      for (p = 0; p < 6; p++) begin
         write_crlf(settings[p]);
         // In one phase, stop the receiver for a long stretch while the input
         // keeps coming back to back, so the queue fills and req_stall rises.
         no_gaps = (p == 1);
         if (p == 1)
            hold_asked++;
         burst_left = 0;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_plan({pick_code(), 1'b0, 3'd0, 48'h0});
            pace_input();
         end
      end
      req_valid <= 1'b0;

      // Drain, then give stray bytes a chance to show up.
      while (plans.size() != 0 || bytes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (plans.size() != 0 || bytes_due.size() != 0)
         report_mismatch($sformatf("%0d bytes never came out", bytes_due.size()));

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### utf8_encoder_six_byte_top.f
+incdir+hw/rtl
hw/rtl/utf8e_pkg.sv
hw/rtl/utf8e_front.sv
hw/rtl/utf8e_queue.sv
hw/rtl/utf8e_back.sv
hw/rtl/utf8_encoder_six_byte_top.sv
sim/utf8_encoder_six_byte_top_tb.sv
